// ===== hdl/wcavg_pkg.sv =====
// ----------------------------------------------------------------------------
// wcavg_pkg
// Shared constants for the windowed count average block.
// ----------------------------------------------------------------------------
package wcavg_pkg;

  // Field widths
  localparam int CountW  = 24;   // per-second count
  localparam int GrandW  = 32;   // wrapping grand total
  localparam int WsumW   = 31;   // window sum
  localparam int WinW    = 7;    // window size and samples used
  localparam int FracOutW = 10;  // thousandths

  // Window limits
  localparam int MaxWindow   = 127;
  localparam int ResetWindow = 10;
  localparam int RingDepth   = MaxWindow + 1;
  localparam int RingAw      = $clog2(RingDepth);

  // Divider sizing: quotient pass over the window sum, fraction pass over
  // remainder * 1000
  localparam int Thousand = 1000;
  localparam int DivW     = WsumW;
  localparam int FracW    = $clog2(MaxWindow * Thousand);
  localparam int DivCntW  = $clog2(DivW);

endpackage

// ===== hdl/wcavg_if.sv =====
// ----------------------------------------------------------------------------
// wcavg_if
// Valid/ready channels of the windowed count average block.
// ----------------------------------------------------------------------------

// Input channel: one per-second count per transaction
interface wcavg_in_if;
  logic                           valid;
  logic                           ready;
  logic [wcavg_pkg::CountW-1:0]   second_count_value;

  modport source (output valid, output second_count_value, input ready);
  modport sink   (input valid, input second_count_value, output ready);
endinterface

// Result channel: totals and average per transaction
interface wcavg_out_if;
  logic                            valid;
  logic                            ready;
  logic [wcavg_pkg::GrandW-1:0]    grand_total;
  logic [wcavg_pkg::WsumW-1:0]     window_total;
  logic [wcavg_pkg::CountW-1:0]    average_whole;
  logic [wcavg_pkg::FracOutW-1:0]  average_thousandths;
  logic [wcavg_pkg::WinW-1:0]      samples_used;

  modport source (output valid, output grand_total, output window_total,
                  output average_whole, output average_thousandths,
                  output samples_used, input ready);
  modport sink   (input valid, input grand_total, input window_total,
                  input average_whole, input average_thousandths,
                  input samples_used, output ready);
endinterface

// Configuration channel: window size write
interface wcavg_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wcavg_pkg::WinW-1:0]   window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

// ===== hdl/wcavg_ram.sv =====
// ----------------------------------------------------------------------------
// wcavg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wcavg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/windowed_count_average_core.sv =====
// ----------------------------------------------------------------------------
// windowed_count_average_core
// Running grand total, windowed sum over a count ring and its average with
// thousandths, from a bit-serial divider.
// ----------------------------------------------------------------------------
//
//  Port   | Dir | Carries
//  -------+-----+---------------------------------------------------------
//  cfg_i  | in  | window_size write (clears the window state)
//  in_i   | in  | second_count_value
//  out_o  | out | grand_total, window_total, average_whole,
//         |     | average_thousandths, samples_used
//
//  Each item runs in order: accept with ring write/read, the registered ring
//  read and sum update, 31 quotient steps and 17 fraction steps of the shared
//  shift-subtract divider, then loading the result into the output register.
//  Reset clears all control registers; the ring gets no clearing pass, ring
//  entries not yet reached since the last clear read as zero via a wrap flag.
//  in_i is ready only between items; a result waits in the output register,
//  and a finished item holds in its last step until that register is free.
// ----------------------------------------------------------------------------
module windowed_count_average_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  wcavg_cfg_if.sink     cfg_i,
  wcavg_in_if.sink      in_i,
  wcavg_out_if.source   out_o
);

  // Sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StDivQ = 3'd2;
  localparam logic [2:0] StDivF = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]                         state_q, state_d;
  logic [wcavg_pkg::WinW-1:0]         win_q, win_d;
  logic [wcavg_pkg::RingAw-1:0]       pos_q, pos_d;
  logic [wcavg_pkg::WinW-1:0]         fill_q, fill_d;
  logic                               wrapped_q, wrapped_d;
  logic                               leave_ok_q, leave_ok_d;
  logic [wcavg_pkg::WsumW-1:0]        wsum_q, wsum_d;
  logic [wcavg_pkg::GrandW-1:0]       grand_q, grand_d;
  logic [wcavg_pkg::CountW-1:0]       val_q, val_d;
  logic [wcavg_pkg::DivW-1:0]         div_q, div_d;
  logic [wcavg_pkg::WinW-1:0]         rem_q, rem_d;
  logic [wcavg_pkg::DivCntW-1:0]      cnt_q, cnt_d;
  logic [wcavg_pkg::CountW-1:0]       whole_q, whole_d;
  logic [wcavg_pkg::FracOutW-1:0]     frac_q, frac_d;

  logic                               ov_q, ov_d;
  logic [wcavg_pkg::GrandW-1:0]       o_grand_q, o_grand_d;
  logic [wcavg_pkg::WsumW-1:0]        o_wsum_q, o_wsum_d;
  logic [wcavg_pkg::CountW-1:0]       o_whole_q, o_whole_d;
  logic [wcavg_pkg::FracOutW-1:0]     o_frac_q, o_frac_d;
  logic [wcavg_pkg::WinW-1:0]         o_fill_q, o_fill_d;

  logic                               in_acc;
  logic [wcavg_pkg::RingAw-1:0]       wr_pos;
  logic                               wrap_now;
  logic [wcavg_pkg::RingAw-1:0]       nxt_pos;
  logic [wcavg_pkg::CountW-1:0]       rd_data;
  logic [wcavg_pkg::CountW-1:0]       leaving;
  logic [wcavg_pkg::WsumW:0]          wsum_ext;
  logic [wcavg_pkg::WinW:0]           trial;
  logic                               trial_ge;
  logic [wcavg_pkg::WinW-1:0]         step_rem;
  logic [wcavg_pkg::DivW-1:0]         step_div;
  logic [wcavg_pkg::FracW-1:0]        frac_prod;
  logic [wcavg_pkg::WinW-1:0]         cfg_win;

  // Handshakes
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == StIdle);
  assign in_acc      = in_i.valid && in_i.ready;

  // Ring pointer: write at the current slot, read the slot it advances to
  assign wr_pos   = (pos_q > win_q) ? '0 : pos_q;
  assign wrap_now = (wr_pos >= win_q);
  assign nxt_pos  = wrap_now ? '0 : wr_pos + 1'b1;

  // Count ring
  wcavg_ram #(
    .Width (wcavg_pkg::CountW),
    .Depth (wcavg_pkg::RingDepth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wr_pos),
    .wdata_i (in_i.second_count_value),
    .re_i    (in_acc),
    .raddr_i (nxt_pos),
    .rdata_o (rd_data)
  );

  // Entry leaving the window; slots not written since the clear read as zero
  assign leaving  = leave_ok_q ? rd_data : '0;
  assign wsum_ext = {1'b0, wsum_q} + (wcavg_pkg::WsumW+1)'(val_q)
                    - (wcavg_pkg::WsumW+1)'(leaving);

  // One shift-subtract divider step, divisor = samples used
  assign trial    = {rem_q, div_q[wcavg_pkg::DivW-1]};
  assign trial_ge = (trial >= {1'b0, fill_q});
  assign step_rem = trial_ge ? wcavg_pkg::WinW'(trial - {1'b0, fill_q})
                             : trial[wcavg_pkg::WinW-1:0];
  assign step_div = {div_q[wcavg_pkg::DivW-2:0], trial_ge};

  // Remainder scaled by one thousand for the fraction pass
  assign frac_prod = wcavg_pkg::FracW'(step_rem) *
                     wcavg_pkg::FracW'(wcavg_pkg::Thousand);

  // Window size as written: zero taken as one, saturate at the ring limit
  always_comb begin
    cfg_win = cfg_i.window_size;
    if (cfg_win == '0) begin
      cfg_win = wcavg_pkg::WinW'(1);
    end
    if (int'(cfg_win) > wcavg_pkg::MaxWindow) begin
      cfg_win = wcavg_pkg::WinW'(wcavg_pkg::MaxWindow);
    end
  end

  // Sequencer and datapath
  always_comb begin
    state_d    = state_q;
    win_d      = win_q;
    pos_d      = pos_q;
    fill_d     = fill_q;
    wrapped_d  = wrapped_q;
    leave_ok_d = leave_ok_q;
    wsum_d     = wsum_q;
    grand_d    = grand_q;
    val_d      = val_q;
    div_d      = div_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    whole_d    = whole_q;
    frac_d     = frac_q;
    ov_d       = ov_q && !out_o.ready;
    o_grand_d  = o_grand_q;
    o_wsum_d   = o_wsum_q;
    o_whole_d  = o_whole_q;
    o_frac_d   = o_frac_q;
    o_fill_d   = o_fill_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          grand_d    = grand_q + wcavg_pkg::GrandW'(in_i.second_count_value);
          val_d      = in_i.second_count_value;
          pos_d      = nxt_pos;
          leave_ok_d = wrapped_q || wrap_now;
          wrapped_d  = wrapped_q || wrap_now;
          if (fill_q < win_q) begin
            fill_d = fill_q + 1'b1;
          end
          state_d = StRead;
        end
      end
      StRead: begin
        wsum_d  = wsum_ext[wcavg_pkg::WsumW-1:0];
        div_d   = wsum_ext[wcavg_pkg::WsumW-1:0];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = StDivQ;
      end
      StDivQ: begin
        div_d = step_div;
        rem_d = step_rem;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == wcavg_pkg::DivCntW'(wcavg_pkg::DivW - 1)) begin
          whole_d = step_div[wcavg_pkg::CountW-1:0];
          div_d   = {frac_prod, (wcavg_pkg::DivW - wcavg_pkg::FracW)'(0)};
          rem_d   = '0;
          cnt_d   = '0;
          state_d = StDivF;
        end
      end
      StDivF: begin
        div_d = step_div;
        rem_d = step_rem;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == wcavg_pkg::DivCntW'(wcavg_pkg::FracW - 1)) begin
          frac_d  = step_div[wcavg_pkg::FracOutW-1:0];
          state_d = StDone;
        end
      end
      StDone: begin
        if (!ov_q || out_o.ready) begin
          ov_d      = 1'b1;
          o_grand_d = grand_q;
          o_wsum_d  = wsum_q;
          o_whole_d = whole_q;
          o_frac_d  = frac_q;
          o_fill_d  = fill_q;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // Window size write clears the window state, grand total kept
    if (cfg_i.valid && cfg_i.ready) begin
      win_d      = cfg_win;
      pos_d      = '0;
      fill_d     = '0;
      wsum_d     = '0;
      wrapped_d  = 1'b0;
      leave_ok_d = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      win_q      <= wcavg_pkg::WinW'(wcavg_pkg::ResetWindow);
      pos_q      <= '0;
      fill_q     <= '0;
      wrapped_q  <= 1'b0;
      leave_ok_q <= 1'b0;
      wsum_q     <= '0;
      grand_q    <= '0;
      cnt_q      <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      win_q      <= win_d;
      pos_q      <= pos_d;
      fill_q     <= fill_d;
      wrapped_q  <= wrapped_d;
      leave_ok_q <= leave_ok_d;
      wsum_q     <= wsum_d;
      grand_q    <= grand_d;
      cnt_q      <= cnt_d;
      ov_q       <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    whole_q   <= whole_d;
    frac_q    <= frac_d;
    o_grand_q <= o_grand_d;
    o_wsum_q  <= o_wsum_d;
    o_whole_q <= o_whole_d;
    o_frac_q  <= o_frac_d;
    o_fill_q  <= o_fill_d;
  end

  // Result channel
  assign out_o.valid               = ov_q;
  assign out_o.grand_total         = o_grand_q;
  assign out_o.window_total        = o_wsum_q;
  assign out_o.average_whole       = o_whole_q;
  assign out_o.average_thousandths = o_frac_q;
  assign out_o.samples_used        = o_fill_q;

endmodule

// ===== tb/wcavg_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wcavg_checker
// Watches the window size, count and result channels of the windowed count
// average core. It keeps its own copy of the count ring and the two running
// sums, predicts each result when a count is accepted and compares every
// accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module wcavg_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  wcavg_cfg_if        cfg_i,
  wcavg_in_if         in_i,
  wcavg_out_if        res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  typedef struct packed {
    logic [wcavg_pkg::GrandW-1:0]   grand_total;
    logic [wcavg_pkg::WsumW-1:0]    window_total;
    logic [wcavg_pkg::CountW-1:0]   average_whole;
    logic [wcavg_pkg::FracOutW-1:0] average_thousandths;
    logic [wcavg_pkg::WinW-1:0]     samples_used;
  } average_t;

  // Shadow of the block state
  logic [wcavg_pkg::CountW-1:0] count_ring [wcavg_pkg::RingDepth];
  int unsigned                  ring_pos;
  int unsigned                  fill_count;
  int unsigned                  window_len;
  logic [wcavg_pkg::WsumW-1:0]  window_sum;
  logic [wcavg_pkg::GrandW-1:0] grand_sum;

  average_t average_q [$];
  average_t want;

  initial begin
    fail_count_o = 0;
    checked_o    = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                checked_o, name, got, exp_val));
    end
  endtask

  // Window state goes back to empty; the grand total is untouched
  function automatic void clear_window();
    foreach (count_ring[i]) count_ring[i] = '0;
    ring_pos   = 0;
    fill_count = 0;
    window_sum = '0;
  endfunction

  // A window size of zero counts as one, anything past the ring saturates
  function automatic void set_window(input logic [wcavg_pkg::WinW-1:0] size);
    window_len = size;
    if (window_len == 0) window_len = 1;
    if (window_len > wcavg_pkg::MaxWindow) window_len = wcavg_pkg::MaxWindow;
    clear_window();
  endfunction

  // One count in: update ring and sums, work out the average
  function automatic average_t advance_window(input logic [wcavg_pkg::CountW-1:0] cnt);
    average_t    r;
    int unsigned leaving;
    int unsigned rest;
    logic [31:0] sum_next;
    grand_sum = grand_sum + wcavg_pkg::GrandW'(cnt);
    if (ring_pos > window_len || ring_pos >= wcavg_pkg::RingDepth) ring_pos = 0;
    count_ring[ring_pos] = cnt;
    ring_pos++;
    if (ring_pos >= window_len + 1 || ring_pos >= wcavg_pkg::RingDepth) ring_pos = 0;
    leaving    = count_ring[ring_pos];
    sum_next   = {1'b0, window_sum} + 32'(cnt) - leaving;
    window_sum = sum_next[wcavg_pkg::WsumW-1:0];
    if (fill_count < window_len) fill_count++;
    if (fill_count == 0) fill_count = 1;
    rest = window_sum % fill_count;
    r.grand_total         = grand_sum;
    r.window_total        = window_sum;
    r.average_whole       = wcavg_pkg::CountW'(window_sum / fill_count);
    r.average_thousandths = wcavg_pkg::FracOutW'((rest * wcavg_pkg::Thousand) / fill_count);
    r.samples_used        = wcavg_pkg::WinW'(fill_count);
    return r;
  endfunction

  // Sample all three channels at each rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_window();
      grand_sum  = '0;
      window_len = wcavg_pkg::ResetWindow;
      average_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (average_q.size() == 0) begin
          report_mismatch($sformatf("result with no count pending, grand total %0d",
                                    res_i.grand_total));
        end else begin
          want = average_q.pop_front();
          compare_field("grand_total", res_i.grand_total, want.grand_total);
          compare_field("window_total", res_i.window_total, want.window_total);
          compare_field("average_whole", res_i.average_whole, want.average_whole);
          compare_field("average_thousandths", res_i.average_thousandths,
                        want.average_thousandths);
          compare_field("samples_used", res_i.samples_used, want.samples_used);
          checked_o++;
        end
      end
      if (cfg_i.valid && cfg_i.ready) set_window(cfg_i.window_size);
      if (in_i.valid && in_i.ready) begin
        average_q.push_back(advance_window(in_i.second_count_value));
      end
    end
    pending_o <= average_q.size();
  end

endmodule

// ===== tb/tb_windowed_count_average_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_count_average_core
// Drives per-second counts and window size writes into the windowed count
// average core: a short directed run over the field extremes and the odd
// window sizes, then random phases, each under a fresh window size. Both
// channels idle at random except for one steady phase; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_windowed_count_average_core;

  localparam int ItemTarget  = 1300;
  localparam int DrainCycles = 64;
  localparam int CycleLimit  = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        steady_run = 1'b0;
  int unsigned items_sent = 0;
  int unsigned size_writes = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  wcavg_cfg_if cfg_w ();
  wcavg_in_if  in_w ();
  wcavg_out_if out_w ();

  windowed_count_average_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_w),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  wcavg_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_w),
    .in_i         (in_w),
    .res_i        (out_w),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: ready drops at random about 9 times in a hundred, none in the steady phase
  always @(posedge clk_i) begin
    out_w.ready <= steady_run || ($urandom_range(0, 99) >= 9);
  end

  // Half full-range random counts, the rest zero, full scale and the edges near both
  function automatic logic [wcavg_pkg::CountW-1:0] random_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return '1;
      3:       return wcavg_pkg::CountW'($urandom_range(0, 15));
      4:       return '1 - wcavg_pkg::CountW'($urandom_range(0, 15));
      default: return wcavg_pkg::CountW'($urandom);
    endcase
  endfunction

  // One count transaction; valid stays high into the next one unless a gap falls
  task automatic send_count(input logic [wcavg_pkg::CountW-1:0] value);
    int unsigned gap;
    gap = 0;
    if (!steady_run && $urandom_range(0, 99) < 9) gap = $urandom_range(1, 80);
    if (gap != 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_w.valid              <= 1'b1;
    in_w.second_count_value <= value;
    do @(posedge clk_i); while (!in_w.ready);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_idle();
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [wcavg_pkg::WinW-1:0] size);
    cfg_w.valid       <= 1'b1;
    cfg_w.window_size <= size;
    do @(posedge clk_i); while (!cfg_w.ready);
    cfg_w.valid <= 1'b0;
    size_writes++;
    @(posedge clk_i);
  endtask

  initial begin
    logic [wcavg_pkg::WinW-1:0] size;
    int unsigned                span;
    int unsigned                phase;

    cfg_w.valid             = 1'b0;
    cfg_w.window_size       = '0;
    in_w.valid              = 1'b0;
    in_w.second_count_value = '0;
    out_w.ready             = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset window of ten: extremes, alternating bits, then wrap past the window
    send_count('0);
    send_count('1);
    send_count(24'd1);
    send_count(24'h800000);
    send_count(24'h7FFFFF);
    send_count(24'h555555);
    send_count(24'hAAAAAA);
    repeat (5) send_count('1);
    wait_idle();

    // Size zero is taken as one
    write_window('0);
    send_count('1);
    send_count(24'd3);
    send_count('0);
    wait_idle();

    // Largest window
    write_window(wcavg_pkg::WinW'(wcavg_pkg::MaxWindow));
    send_count('1);
    send_count(24'd1);
    send_count(24'd2);
    wait_idle();

    // Size one, then two, after earlier history
    write_window(wcavg_pkg::WinW'(1));
    send_count(24'd7);
    send_count(24'd5);
    wait_idle();
    write_window(wcavg_pkg::WinW'(2));
    send_count(24'd7);
    send_count('0);
    send_count(24'd5);
    wait_idle();

    // Random phases, each under its own window size
    phase = 0;
    while (items_sent < ItemTarget) begin
      case (phase)
        0:       begin size = wcavg_pkg::WinW'(wcavg_pkg::MaxWindow); span = 120; end
        1:       begin size = wcavg_pkg::WinW'(1);                    span = 60;  end
        2:       begin size = '0;                                     span = 40;  end
        3:       begin
          size = wcavg_pkg::WinW'($urandom_range(2, wcavg_pkg::MaxWindow - 1));
          span = 150;
        end
        default: begin
          size = wcavg_pkg::WinW'($urandom_range(0, wcavg_pkg::MaxWindow));
          span = $urandom_range(10, 160);
        end
      endcase
      steady_run <= (phase == 3);
      write_window(size);
      // Full window of full-scale counts drives the window sum to its top
      if (phase == 0) begin
        repeat (wcavg_pkg::MaxWindow + 13) send_count('1);
      end
      repeat (span) send_count(random_count());
      wait_idle();
      phase++;
    end

    steady_run <= 1'b0;
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb: %0d counts sent under %0d window size writes, %0d results compared",
             items_sent, size_writes, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== windowed_count_average_core.f =====
hdl/wcavg_pkg.sv
hdl/wcavg_if.sv
hdl/wcavg_ram.sv
hdl/windowed_count_average_core.sv
tb/wcavg_checker.sv
tb/tb_windowed_count_average_core.sv
